/* hdl/ldr_pkg.sv */
// Shared types, constants and saturating arithmetic for the lens distortion remap core.
`default_nettype none

package ldr_pkg;

   // Fixed-point word: signed, 28 fraction bits, held within +-(2^62 - 1)
   localparam int QW    = 63;
   localparam int MAG_W = QW - 1;
   localparam int FRAC  = 28;

   typedef logic signed [QW-1:0] q_type;

   localparam q_type QLIM = 63'sh3FFF_FFFF_FFFF_FFFF;

   // Field widths
   localparam int COORD_W  = 12;
   localparam int FOCAL_W  = 32;
   localparam int CENTRE_W = 28;
   localparam int COEF_W   = 32;
   localparam int CSR_W    = 32;
   localparam int REG_IDX_W = 3;

   // Divider geometry: magnitude of the centred coordinate, quotient bits
   localparam int DX_W  = 28;
   localparam int QUO_W = DX_W + FRAC;
   localparam int DIV_W = 32;

   // Multiplier split into 32-bit halves
   localparam int HALF_W  = 32;
   localparam int PROD_W  = 4 * HALF_W;
   localparam int MUL_LAT = 5;

   // Pixel positions carry 16 fraction bits
   localparam int PIX_FRAC = 16;

   // Reset values of the register file
   localparam logic [FOCAL_W-1:0]  FOCAL_RST    = 32'd32768000;
   localparam logic [CENTRE_W-1:0] CENTRE_X_RST = 28'd20971520;
   localparam logic [CENTRE_W-1:0] CENTRE_Y_RST = 28'd15728640;

   localparam int IMG_WIDTH_DEF  = 640;
   localparam int IMG_HEIGHT_DEF = 480;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_FOCAL_X       = 3'd0,
      REG_FOCAL_Y       = 3'd1,
      REG_CENTRE_X      = 3'd2,
      REG_CENTRE_Y      = 3'd3,
      REG_RADIAL_K1     = 3'd4,
      REG_RADIAL_K2     = 3'd5,
      REG_TANGENTIAL_P1 = 3'd6,
      REG_TANGENTIAL_P2 = 3'd7
   } reg_index_type;

   // Add two words and clamp the sum to +-QLIM
   function automatic q_type sat_add(input q_type a, input q_type b);
      logic signed [QW:0] s;
      logic signed [QW:0] hi;
      logic signed [QW:0] lo;
      hi = (QW+1)'(QLIM);
      lo = -hi;
      s  = (QW+1)'(a) + (QW+1)'(b);
      if (s > hi) begin
         return QLIM;
      end else if (s < lo) begin
         return -QLIM;
      end else begin
         return s[QW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/lens_distortion_remap_core.sv */
// Top level of the radial-tangential lens distortion remap core.
//
// Usage: drive an output pixel on req_out_col / req_out_row with start high;
// the beat is taken at a rising edge where start is high and busy is low.
// busy is only high while reset is held, so one beat can be taken every cycle.
// Each beat yields exactly one result beat: rsp_valid is high for one cycle
// with rsp_src_col, rsp_src_row and rsp_in_bounds. Results come out in order.
// Pipeline: the 56-stage divider (one quotient bit per stage) for normalisation
// is followed by 5-stage multipliers and saturating adders, laid out as a
// straight pipeline.
// Throughput: one pixel per clock, since every stage advances each cycle.
// Configuration: csr_we writes csr_data into register csr_index at the next
// edge; write only while no beats are in flight.
// Reset: clears the in-flight valid line and reloads the register defaults
// (focal lengths 500.0, centre 320.0 / 240.0, coefficients zero).
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none

module lens_distortion_remap_core
   import ldr_pkg::*;
#(
   parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = IMG_HEIGHT_DEF
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [COORD_W-1:0]   req_out_col,
   input  wire logic [COORD_W-1:0]   req_out_row,
   output logic                      rsp_valid,
   output logic [COORD_W-1:0]        rsp_src_col,
   output logic [COORD_W-1:0]        rsp_src_row,
   output logic                      rsp_in_bounds,
   input  wire logic                 csr_we,
   input  wire logic [REG_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   localparam int LAT     = 89;
   localparam int MX_DLY  = 22;
   localparam int MX_TAP_RATIO = 16;
   localparam int MX_TAP_SUM   = 21;
   localparam int K1_DLY  = 5;
   localparam int TX_DLY  = 10;

   localparam logic signed [QW:0] HALF_PIX   = (QW+1)'(1) <<< (PIX_FRAC - 1);
   localparam logic signed [QW:0] PIX_NEG_END = -((QW+1)'(1) <<< PIX_FRAC);
   localparam logic signed [QW:0] COL_END    = (QW+1)'(IMG_WIDTH) <<< PIX_FRAC;
   localparam logic signed [QW:0] ROW_END    = (QW+1)'(IMG_HEIGHT) <<< PIX_FRAC;

   // Register file
   logic [FOCAL_W-1:0]  focal_x_ff, focal_y_ff;
   logic [DIV_W-1:0]    div_x_ff, div_y_ff;
   logic [CENTRE_W-1:0] centre_x_ff, centre_y_ff;
   logic signed [COEF_W-1:0] radial_k1_ff, radial_k2_ff;
   logic signed [COEF_W-1:0] tangential_p1_ff, tangential_p2_ff;
   logic [DIV_W-1:0]    div_in;

   q_type k1_q, k2_q, p1_q, p2_q, focal_x_q, focal_y_q;

   // Valid line
   logic [LAT-1:0] vld_ff;

   // Centred coordinates
   logic signed [DX_W:0] dx_x, dx_y;
   logic [DX_W-1:0] mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;
   logic            neg_x_ff, neg_y_ff;

   // Datapath words
   q_type mx, my, mxx, myy, mxy;
   q_type rho_ff, mxx2_ff, myy2_ff, mxy2_ff;
   q_type sx_ff, sy_ff;
   q_type rho2, k1rho, k2rho2, p1mxy2, p2mxy2, p2sx, p1sy;
   q_type p1mxy2_ff, p2mxy2_ff;
   q_type tx_ff, ty_ff;
   q_type ratio_ff;
   q_type mxr, myr;
   q_type ux_ff, uy_ff;
   q_type udx_ff, udy_ff;
   q_type pmx, pmy;
   q_type mx_dly_ff [MX_DLY];
   q_type my_dly_ff [MX_DLY];
   q_type k1rho_dly_ff [K1_DLY];
   q_type tx_dly_ff [TX_DLY];
   q_type ty_dly_ff [TX_DLY];

   logic signed [QW:0] px_ff, py_ff, px_in, py_in;
   logic               in_x, in_y, in_image;
   logic [COORD_W-1:0] col_in, row_in;

   logic [COORD_W-1:0] src_col_ff, src_row_ff;
   logic               in_bounds_ff;

   assign busy = reset;

   // Write the register file; a zero focal length divides as one LSB
   assign div_in = (csr_data == '0) ? DIV_W'(1) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff       <= FOCAL_RST;
         focal_y_ff       <= FOCAL_RST;
         div_x_ff         <= FOCAL_RST;
         div_y_ff         <= FOCAL_RST;
         centre_x_ff      <= CENTRE_X_RST;
         centre_y_ff      <= CENTRE_Y_RST;
         radial_k1_ff     <= '0;
         radial_k2_ff     <= '0;
         tangential_p1_ff <= '0;
         tangential_p2_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_FOCAL_X: begin
               focal_x_ff <= csr_data;
               div_x_ff   <= div_in;
            end
            REG_FOCAL_Y: begin
               focal_y_ff <= csr_data;
               div_y_ff   <= div_in;
            end
            REG_CENTRE_X:      centre_x_ff      <= csr_data[CENTRE_W-1:0];
            REG_CENTRE_Y:      centre_y_ff      <= csr_data[CENTRE_W-1:0];
            REG_RADIAL_K1:     radial_k1_ff     <= csr_data;
            REG_RADIAL_K2:     radial_k2_ff     <= csr_data;
            REG_TANGENTIAL_P1: tangential_p1_ff <= csr_data;
            REG_TANGENTIAL_P2: tangential_p2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      k1_q      = q_type'(radial_k1_ff);
      k2_q      = q_type'(radial_k2_ff);
      p1_q      = q_type'(tangential_p1_ff);
      p2_q      = q_type'(tangential_p2_ff);
      focal_x_q = q_type'(focal_x_ff);
      focal_y_q = q_type'(focal_y_ff);
   end

   // Advance the valid line one stage per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start & ~busy};
      end
   end

   // Centre the pixel and split it into sign and magnitude
   always_comb begin
      dx_x     = $signed({1'b0, req_out_col, {PIX_FRAC{1'b0}}}) - $signed({1'b0, centre_x_ff});
      dx_y     = $signed({1'b0, req_out_row, {PIX_FRAC{1'b0}}}) - $signed({1'b0, centre_y_ff});
      mag_x_in = dx_x[DX_W] ? DX_W'(-dx_x) : dx_x[DX_W-1:0];
      mag_y_in = dx_y[DX_W] ? DX_W'(-dx_y) : dx_y[DX_W-1:0];
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      neg_x_ff <= dx_x[DX_W];
      neg_y_ff <= dx_y[DX_W];
   end

   // Normalise by the focal lengths
   ldr_div u_div_x (
      .clock    (clock),
      .num_mag  (mag_x_ff),
      .num_neg  (neg_x_ff),
      .divisor  (div_x_ff),
      .quotient (mx)
   );

   ldr_div u_div_y (
      .clock    (clock),
      .num_mag  (mag_y_ff),
      .num_neg  (neg_y_ff),
      .divisor  (div_y_ff),
      .quotient (my)
   );

   // Squares and cross term
   ldr_mulq u_mul_xx (.clock(clock), .op_a(mx), .op_b(mx), .product(mxx));
   ldr_mulq u_mul_yy (.clock(clock), .op_a(my), .op_b(my), .product(myy));
   ldr_mulq u_mul_xy (.clock(clock), .op_a(mx), .op_b(my), .product(mxy));

   // Radius squared, the doubled terms and their sums with the radius squared
   always_ff @(posedge clock) begin
      rho_ff  <= sat_add(mxx, myy);
      mxx2_ff <= sat_add(mxx, mxx);
      myy2_ff <= sat_add(myy, myy);
      mxy2_ff <= sat_add(mxy, mxy);
      sx_ff   <= sat_add(rho_ff, mxx2_ff);
      sy_ff   <= sat_add(rho_ff, myy2_ff);
   end

   ldr_mulq u_mul_rho2  (.clock(clock), .op_a(rho_ff), .op_b(rho_ff),  .product(rho2));
   ldr_mulq u_mul_k1rho (.clock(clock), .op_a(k1_q),   .op_b(rho_ff),  .product(k1rho));
   ldr_mulq u_mul_p1xy  (.clock(clock), .op_a(p1_q),   .op_b(mxy2_ff), .product(p1mxy2));
   ldr_mulq u_mul_p2xy  (.clock(clock), .op_a(p2_q),   .op_b(mxy2_ff), .product(p2mxy2));
   ldr_mulq u_mul_p2sx  (.clock(clock), .op_a(p2_q),   .op_b(sx_ff),   .product(p2sx));
   ldr_mulq u_mul_p1sy  (.clock(clock), .op_a(p1_q),   .op_b(sy_ff),   .product(p1sy));
   ldr_mulq u_mul_k2rho (.clock(clock), .op_a(k2_q),   .op_b(rho2),    .product(k2rho2));

   // Tangential offsets
   always_ff @(posedge clock) begin
      p1mxy2_ff <= p1mxy2;
      p2mxy2_ff <= p2mxy2;
      tx_ff     <= sat_add(p1mxy2_ff, p2sx);
      ty_ff     <= sat_add(p1sy, p2mxy2_ff);
   end

   // Hold operands until their partners arrive
   always_ff @(posedge clock) begin
      mx_dly_ff[0]    <= mx;
      my_dly_ff[0]    <= my;
      k1rho_dly_ff[0] <= k1rho;
      tx_dly_ff[0]    <= tx_ff;
      ty_dly_ff[0]    <= ty_ff;
      for (int i = 1; i < MX_DLY; i++) begin
         mx_dly_ff[i] <= mx_dly_ff[i-1];
         my_dly_ff[i] <= my_dly_ff[i-1];
      end
      for (int i = 1; i < K1_DLY; i++) begin
         k1rho_dly_ff[i] <= k1rho_dly_ff[i-1];
      end
      for (int i = 1; i < TX_DLY; i++) begin
         tx_dly_ff[i] <= tx_dly_ff[i-1];
         ty_dly_ff[i] <= ty_dly_ff[i-1];
      end
   end

   // Radial gain
   always_ff @(posedge clock) begin
      ratio_ff <= sat_add(k1rho_dly_ff[K1_DLY-1], k2rho2);
   end

   ldr_mulq u_mul_xr (.clock(clock), .op_a(mx_dly_ff[MX_TAP_RATIO]), .op_b(ratio_ff),
                      .product(mxr));
   ldr_mulq u_mul_yr (.clock(clock), .op_a(my_dly_ff[MX_TAP_RATIO]), .op_b(ratio_ff),
                      .product(myr));

   // Distorted normalised coordinates
   always_ff @(posedge clock) begin
      ux_ff  <= sat_add(mx_dly_ff[MX_TAP_SUM], mxr);
      uy_ff  <= sat_add(my_dly_ff[MX_TAP_SUM], myr);
      udx_ff <= sat_add(ux_ff, tx_dly_ff[TX_DLY-1]);
      udy_ff <= sat_add(uy_ff, ty_dly_ff[TX_DLY-1]);
   end

   // Map back to pixels
   ldr_mulq u_mul_fx (.clock(clock), .op_a(focal_x_q), .op_b(udx_ff), .product(pmx));
   ldr_mulq u_mul_fy (.clock(clock), .op_a(focal_y_q), .op_b(udy_ff), .product(pmy));

   // Add centre and half a pixel in a word one bit wider, so the sum cannot overflow
   always_comb begin
      px_in = (QW+1)'(pmx) + $signed((QW+1)'(centre_x_ff)) + HALF_PIX;
      py_in = (QW+1)'(pmy) + $signed((QW+1)'(centre_y_ff)) + HALF_PIX;
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
   end

   // Truncate toward zero and test the image bounds
   always_comb begin
      in_x     = (px_ff > PIX_NEG_END) && (px_ff < COL_END);
      in_y     = (py_ff > PIX_NEG_END) && (py_ff < ROW_END);
      in_image = in_x & in_y;
      col_in   = px_ff[QW] ? '0 : px_ff[PIX_FRAC +: COORD_W];
      row_in   = py_ff[QW] ? '0 : py_ff[PIX_FRAC +: COORD_W];
   end

   always_ff @(posedge clock) begin
      in_bounds_ff <= in_image;
      src_col_ff   <= in_image ? col_in : '0;
      src_row_ff   <= in_image ? row_in : '0;
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_src_col   = src_col_ff;
   assign rsp_src_row   = src_row_ff;
   assign rsp_in_bounds = in_bounds_ff;

endmodule

`default_nettype wire

/* hdl/ldr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for coordinate normalisation.
`default_nettype none

module ldr_div
   import ldr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [DX_W-1:0]   num_mag,
   input  wire logic              num_neg,
   input  wire logic [DIV_W-1:0]  divisor,
   output q_type                  quotient
);

   logic [DIV_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] sh_ff  [QUO_W];
   logic             neg_ff [QUO_W];
   logic [DIV_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] sh_in  [QUO_W];

   q_type quotient_ff;
   q_type quotient_in;
   q_type quo_ext;

   // Each stage shifts one dividend bit into the partial remainder and
   // retires one quotient bit at the bottom of the shift word
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [DIV_W-1:0] rem_prev;
      logic [QUO_W-1:0] sh_prev;
      logic [DIV_W:0]   trial;
      logic             take;
      if (s == 0) begin : g_head
         assign rem_prev = '0;
         assign sh_prev  = {num_mag, {FRAC{1'b0}}};
      end else begin : g_body
         assign rem_prev = rem_ff[s-1];
         assign sh_prev  = sh_ff[s-1];
      end
      assign trial     = {rem_prev, sh_prev[QUO_W-1]};
      assign take      = (trial >= {1'b0, divisor});
      assign rem_in[s] = take ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      assign sh_in[s]  = {sh_prev[QUO_W-2:0], take};
   end

   // Advance all stages every cycle
   always_ff @(posedge clock) begin
      neg_ff[0] <= num_neg;
      for (int s = 0; s < QUO_W; s++) begin
         rem_ff[s] <= rem_in[s];
         sh_ff[s]  <= sh_in[s];
      end
      for (int s = 1; s < QUO_W; s++) begin
         neg_ff[s] <= neg_ff[s-1];
      end
   end

   // Apply the sign of the centred coordinate
   always_comb begin
      quo_ext     = q_type'(sh_ff[QUO_W-1]);
      quotient_in = neg_ff[QUO_W-1] ? -quo_ext : quo_ext;
   end

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
   end

   assign quotient = quotient_ff;

endmodule

`default_nettype wire

/* hdl/ldr_mulq.sv */
// Pipelined signed fixed-point multiplier: exact product, shift by 28, truncate, saturate.
`default_nettype none

module ldr_mulq
   import ldr_pkg::*;
(
   input  wire logic  clock,
   input  wire q_type op_a,
   input  wire q_type op_b,
   output q_type      product
);

   // Stage A: magnitudes and result sign
   logic [MAG_W-1:0] mag_a_ff, mag_b_ff, mag_a_in, mag_b_in;
   logic             neg_a_ff;
   q_type            neg_op_a, neg_op_b;

   // Stage B: four 32x32 partial products
   logic [HALF_W-1:0]   lo_a, hi_a, lo_b, hi_b;
   logic [2*HALF_W-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic                neg_b_ff;

   // Stage C: middle column sum
   logic [2*HALF_W:0]   mid_ff;
   logic [2*HALF_W-1:0] ll_c_ff, hh_c_ff;
   logic                neg_c_ff;

   // Stage D: full product
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_d_ff;

   // Stage E: scaled, saturated, signed result
   logic [MAG_W-1:0] res_mag;
   q_type            res_pos;
   q_type            product_ff, product_in;

   always_comb begin
      neg_op_a = -op_a;
      neg_op_b = -op_b;
      mag_a_in = op_a[QW-1] ? neg_op_a[MAG_W-1:0] : op_a[MAG_W-1:0];
      mag_b_in = op_b[QW-1] ? neg_op_b[MAG_W-1:0] : op_b[MAG_W-1:0];
   end

   always_comb begin
      lo_a = mag_a_ff[HALF_W-1:0];
      hi_a = HALF_W'(mag_a_ff[MAG_W-1:HALF_W]);
      lo_b = mag_b_ff[HALF_W-1:0];
      hi_b = HALF_W'(mag_b_ff[MAG_W-1:HALF_W]);
   end

   always_comb begin
      prod_in = {hh_c_ff, ll_c_ff}
              + {{(PROD_W-3*HALF_W-1){1'b0}}, mid_ff, {HALF_W{1'b0}}};
   end

   // Overflow once any bit at or above 2^62 survives the shift
   always_comb begin
      if (|prod_ff[PROD_W-1:FRAC+MAG_W]) begin
         res_mag = QLIM[MAG_W-1:0];
      end else begin
         res_mag = prod_ff[FRAC +: MAG_W];
      end
      res_pos    = {1'b0, res_mag};
      product_in = neg_d_ff ? -res_pos : res_pos;
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_a_ff <= op_a[QW-1] ^ op_b[QW-1];

      pp_ll_ff <= lo_a * lo_b;
      pp_lh_ff <= lo_a * hi_b;
      pp_hl_ff <= hi_a * lo_b;
      pp_hh_ff <= hi_a * hi_b;
      neg_b_ff <= neg_a_ff;

      mid_ff   <= {1'b0, pp_lh_ff} + {1'b0, pp_hl_ff};
      ll_c_ff  <= pp_ll_ff;
      hh_c_ff  <= pp_hh_ff;
      neg_c_ff <= neg_b_ff;

      prod_ff  <= prod_in;
      neg_d_ff <= neg_c_ff;

      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

/* bench/lens_distortion_remap_core_tb.sv */
// Self-checking testbench for the lens distortion remap core.
`timescale 1ns / 1ps

module lens_distortion_remap_core_tb
   import ldr_pkg::*;
();

   localparam int     PIPE_LATENCY = 89;
   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     RANDOM_PHASES = 10;
   localparam int     BEATS_PER_PHASE = 115;
   localparam longint WORD_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               hit;
   } source_pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [COORD_W-1:0]   req_out_col = '0;
   logic [COORD_W-1:0]   req_out_row = '0;
   logic                 rsp_valid;
   logic [COORD_W-1:0]   rsp_src_col;
   logic [COORD_W-1:0]   rsp_src_row;
   logic                 rsp_in_bounds;
   logic                 csr_we = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   // Lens setting as the core should hold it
   logic [FOCAL_W-1:0]       lens_fx = FOCAL_RST;
   logic [FOCAL_W-1:0]       lens_fy = FOCAL_RST;
   logic [CENTRE_W-1:0]      lens_cx = CENTRE_X_RST;
   logic [CENTRE_W-1:0]      lens_cy = CENTRE_Y_RST;
   logic signed [COEF_W-1:0] lens_k1 = '0;
   logic signed [COEF_W-1:0] lens_k2 = '0;
   logic signed [COEF_W-1:0] lens_p1 = '0;
   logic signed [COEF_W-1:0] lens_p2 = '0;

   source_pixel_type expected_sources[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   logic             busy_at_fall = 1'b1;
   bit               gaps_on = 1'b1;

   lens_distortion_remap_core i_dut (.*);

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- arithmetic

   function automatic logic [63:0] magnitude(input longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
   endfunction

   function automatic longint clamp_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > WORD_LIM) return WORD_LIM;
      if (s < -WORD_LIM) return -WORD_LIM;
      return s;
   endfunction

   // Exact product, shifted down by the fraction width with the magnitude truncated and clamped
   function automatic longint fx_mul(input longint a, input longint b);
      logic [127:0] prod;
      logic [127:0] shifted;
      longint       r;
      prod    = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
      shifted = prod >> FRAC;
      if (shifted > 128'(WORD_LIM)) r = WORD_LIM;
      else r = longint'(shifted[63:0]);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   // Centred pixel over focal length, quotient truncated toward zero
   function automatic longint normalise(input logic [COORD_W-1:0] pix,
                                        input logic [CENTRE_W-1:0] centre,
                                        input logic [FOCAL_W-1:0] focal);
      longint      dx;
      logic [63:0] divisor;
      logic [63:0] quo;
      dx      = longint'(pix) * 65536 - longint'(centre);
      divisor = (focal == '0) ? 64'd1 : 64'(focal);
      quo     = (magnitude(dx) << FRAC) / divisor;
      return (dx < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   // Back to pixels: focal * ud + centre + half, truncated toward zero
   function automatic longint to_pixel(input longint ud, input logic [FOCAL_W-1:0] focal,
                                       input logic [CENTRE_W-1:0] centre);
      longint p;
      p = fx_mul(longint'(focal), ud);
      p = clamp_sum(p, longint'(centre));
      p = clamp_sum(p, 64'sd32768);
      if (p >= 0) return p >>> PIX_FRAC;
      return -longint'(magnitude(p) >> PIX_FRAC);
   endfunction

   function automatic source_pixel_type remap_source(input logic [COORD_W-1:0] col,
                                                     input logic [COORD_W-1:0] row);
      longint           mx, my, mxx, myy, mxy, rho, rho2, ratio, mxy2;
      longint           tx, ty, udx, udy, u, v;
      source_pixel_type s;
      mx    = normalise(col, lens_cx, lens_fx);
      my    = normalise(row, lens_cy, lens_fy);
      mxx   = fx_mul(mx, mx);
      myy   = fx_mul(my, my);
      mxy   = fx_mul(mx, my);
      rho   = clamp_sum(mxx, myy);
      rho2  = fx_mul(rho, rho);
      ratio = clamp_sum(fx_mul(longint'(lens_k1), rho), fx_mul(longint'(lens_k2), rho2));
      mxy2  = clamp_sum(mxy, mxy);
      tx    = clamp_sum(fx_mul(longint'(lens_p1), mxy2),
                        fx_mul(longint'(lens_p2), clamp_sum(rho, clamp_sum(mxx, mxx))));
      ty    = clamp_sum(fx_mul(longint'(lens_p1), clamp_sum(rho, clamp_sum(myy, myy))),
                        fx_mul(longint'(lens_p2), mxy2));
      udx   = clamp_sum(clamp_sum(mx, fx_mul(mx, ratio)), tx);
      udy   = clamp_sum(clamp_sum(my, fx_mul(my, ratio)), ty);
      u     = to_pixel(udx, lens_fx, lens_cx);
      v     = to_pixel(udy, lens_fy, lens_cy);
      s.hit = (u >= 0) && (v >= 0) && (u < IMG_WIDTH_DEF) && (v < IMG_HEIGHT_DEF);
      s.col = s.hit ? u[COORD_W-1:0] : '0;
      s.row = s.hit ? v[COORD_W-1:0] : '0;
      return s;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Sample busy and results mid-cycle, clear of the driving edge
   always @(negedge clock) begin
      busy_at_fall <= busy;
   end

   always @(negedge clock) begin
      source_pixel_type want;
      if (!reset && rsp_valid) begin
         if (expected_sources.size() == 0) begin
            flag_mismatch($sformatf("result beat with none expected (col %0d row %0d)",
                                    rsp_src_col, rsp_src_row));
         end else begin
            want = expected_sources.pop_front();
            if (rsp_src_col !== want.col)
               flag_mismatch($sformatf("src_col %0d, want %0d", rsp_src_col, want.col));
            if (rsp_src_row !== want.row)
               flag_mismatch($sformatf("src_row %0d, want %0d", rsp_src_row, want.row));
            if (rsp_in_bounds !== want.hit)
               flag_mismatch($sformatf("in_bounds %0b, want %0b", rsp_in_bounds, want.hit));
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // Offer one pixel, idle at random first, and log its source once taken
   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      while (gaps_on && $urandom_range(99, 0) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_out_col <= col;
      req_out_row <= row;
      do @(posedge clock); while (busy_at_fall);
      expected_sources = {expected_sources, remap_source(col, row)};
   endtask

   // Drop start and hold until every result beat has come back
   task automatic drain_pipeline();
      start <= 1'b0;
      while (expected_sources.size() != 0) @(posedge clock);
   endtask

   task automatic write_lens_reg(input reg_index_type idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         REG_FOCAL_X:       lens_fx = val;
         REG_FOCAL_Y:       lens_fy = val;
         REG_CENTRE_X:      lens_cx = val[CENTRE_W-1:0];
         REG_CENTRE_Y:      lens_cy = val[CENTRE_W-1:0];
         REG_RADIAL_K1:     lens_k1 = val;
         REG_RADIAL_K2:     lens_k2 = val;
         REG_TANGENTIAL_P1: lens_p1 = val;
         REG_TANGENTIAL_P2: lens_p2 = val;
         default: ;
      endcase
   endtask

   // Load a full lens setting; centre words carry random junk above bit 27
   task automatic load_lens(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [27:0] cx, input logic [27:0] cy,
                            input logic [31:0] k1, input logic [31:0] k2,
                            input logic [31:0] p1, input logic [31:0] p2);
      write_lens_reg(REG_FOCAL_X, fx);
      write_lens_reg(REG_FOCAL_Y, fy);
      write_lens_reg(REG_CENTRE_X, {4'($urandom), cx});
      write_lens_reg(REG_CENTRE_Y, {4'($urandom), cy});
      write_lens_reg(REG_RADIAL_K1, k1);
      write_lens_reg(REG_RADIAL_K2, k2);
      write_lens_reg(REG_TANGENTIAL_P1, p1);
      write_lens_reg(REG_TANGENTIAL_P2, p2);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] extreme_word(input logic [31:0] lo, input logic [31:0] hi);
      case ($urandom_range(2, 0))
         0:       return lo;
         1:       return hi;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // Identity mapping out of reset: corners, centre and the image border
   task automatic test_reset_defaults();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd320, 12'd240);
      send_pixel(12'd639, 12'd479);
      send_pixel(12'd640, 12'd480);
      send_pixel(12'd2730, 12'd1365);
      drain_pipeline();
   endtask

   // Push sources just left of and just above the image, where rounding still gives 0
   task automatic test_border_rounding();
      load_lens(FOCAL_RST, FOCAL_RST, CENTRE_X_RST, CENTRE_Y_RST,
                32'sd1536000, 32'sd0, 32'sd0, 32'sd0);
      send_pixel(12'd0, 12'd240);
      send_pixel(12'd1, 12'd240);
      send_pixel(12'd0, 12'd241);
      drain_pipeline();
      load_lens(FOCAL_RST, FOCAL_RST, CENTRE_X_RST, CENTRE_Y_RST,
                32'sd3640889, 32'sd0, 32'sd0, 32'sd0);
      send_pixel(12'd320, 12'd0);
      send_pixel(12'd320, 12'd1);
      send_pixel(12'd321, 12'd0);
      drain_pipeline();
   endtask

   // Zero focal length stands for one LSB
   task automatic test_zero_focal();
      load_lens(32'd0, 32'd0, CENTRE_X_RST, CENTRE_Y_RST, 32'd0, 32'd0, 32'd0, 32'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd320, 12'd240);
      drain_pipeline();
   endtask

   // Full-scale coefficients drive the intermediates into saturation
   task automatic test_huge_distortion();
      load_lens(FOCAL_RST, FOCAL_RST, CENTRE_X_RST, CENTRE_Y_RST,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      drain_pipeline();
      load_lens(32'd65536, 32'hFFFF_FFFF, 28'h0, 28'hFFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd320, 12'd240);
      drain_pipeline();
   endtask

   // Random pixels under a run of lens settings, plausible ones mostly
   task automatic test_random_settings();
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      int                 flavour;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         gaps_on = (phase != 2) && (phase != 3);
         flavour = (phase < 6 || phase == 9) ? 0 : (phase < 8 ? 1 : 2);
         case (flavour)
            0: load_lens({16'($urandom_range(1500, 200)), 16'($urandom)},
                         {16'($urandom_range(1500, 200)), 16'($urandom)},
                         {12'($urandom_range(440, 200)), 16'($urandom)},
                         {12'($urandom_range(330, 150)), 16'($urandom)},
                         int'($urandom_range(268435456, 0)) - 134217728,
                         int'($urandom_range(134217728, 0)) - 67108864,
                         int'($urandom_range(8388608, 0)) - 4194304,
                         int'($urandom_range(8388608, 0)) - 4194304);
            1: load_lens(extreme_word(32'd65536, 32'hFFFF_FFFF),
                         extreme_word(32'd0, 32'hFFFF_FFFF),
                         28'(extreme_word(32'd0, 32'h0FFF_FFFF)),
                         28'(extreme_word(32'd0, 32'h0FFF_FFFF)),
                         extreme_word(32'h8000_0000, 32'h7FFF_FFFF),
                         extreme_word(32'h8000_0000, 32'h7FFF_FFFF),
                         extreme_word(32'h8000_0000, 32'h7FFF_FFFF),
                         extreme_word(32'h8000_0000, 32'h7FFF_FFFF));
            default: load_lens($urandom, $urandom, 28'($urandom), 28'($urandom),
                               $urandom, $urandom, $urandom, $urandom);
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if ($urandom_range(3, 0) == 0) begin
               col = 12'($urandom);
               row = 12'($urandom);
            end else begin
               col = 12'($urandom_range(700, 0));
               row = 12'($urandom_range(540, 0));
            end
            send_pixel(col, row);
         end
         drain_pipeline();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_border_rounding();
      test_zero_focal();
      test_huge_distortion();
      test_random_settings();
      drain_pipeline();
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && expected_sources.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
